FILE: rtl/core/tc_pkg.sv
// shared types, character codes and keyword tables for the token classifier
package tc_pkg;

  typedef enum logic [2:0] {
    CLS_IDENT    = 3'd0,
    CLS_KEYWORD  = 3'd1,
    CLS_CONST    = 3'd2,
    CLS_OPERATOR = 3'd3,
    CLS_DELIM    = 3'd4,
    CLS_COMMENT  = 3'd5,
    CLS_INVALID  = 3'd6
  } token_class_t;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4
  } scan_mode_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_USCR  = 8'h5F;

  localparam int NUM_KW     = 11;
  localparam int KW_MAX_LEN = 6;
  localparam int KW_IDX_W   = 4;

  // keyword text right-aligned, first character in the highest used byte
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [NUM_KW] = '{
    48'("then"), 48'("endif"), 48'("print"), 48'("int"), 48'("float"), 48'("if"),
    48'("else"), 48'("while"), 48'("for"), 48'("do"), 48'("return")
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd4, 3'd5, 3'd5, 3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd3, 3'd2, 3'd6
  };

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    token_class_t cls;
    logic [7:0]   ch;
    logic [3:0]   kw;
    logic [7:0]   len;
    logic         last;
  } tc_result_t;

  typedef struct packed {
    logic [1:0] n;
    tc_result_t r0;
    tc_result_t r1;
  } tc_push_t;

  function automatic logic is_op(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
           c == CH_EQ || c == CH_GT || c == CH_LT;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_COMMA || c == CH_SEMI || c == CH_LPAR || c == CH_RPAR ||
           c == CH_LBRC || c == CH_RBRC || c == CH_LBRK || c == CH_RBRK;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) || c == CH_USCR;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // does character c match keyword k at position pos
  function automatic logic kw_char_hit(input int k, input logic [2:0] pos,
                                       input logic [7:0] c);
    logic hit;
    int   sh;
    hit = 1'b0;
    sh  = 0;
    if (pos < KW_LEN[k]) begin
      sh  = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
      hit = (KW_TEXT[k][sh +: 8] == c);
    end
    return hit;
  endfunction

endpackage

FILE: rtl/core/tc_lexer.sv
// scanner state and per-character classification, up to two results per item
module tc_lexer import tc_pkg::*; #(
  parameter int MAX_WORD_LEN = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output tc_push_t   push
);

  localparam int CW = $clog2(MAX_WORD_LEN + 1);

  scan_mode_t          mode_r, mode_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                digits_r, digits_nxt;
  logic [NUM_KW-1:0]   cand_r, cand_nxt;

  logic [7:0]  c;
  logic        c_op, c_delim, c_word, c_space, c_ends;
  logic        has_word, kw_found, in_range;
  logic [3:0]  kw_idx;
  logic [7:0]  len8;
  logic [NUM_KW-1:0] app_cand;
  tc_result_t  word_res, tok_res, pre_res, slot0, slot1;
  logic        pre_v, flush_v, tok_v, do_append, do_clear;
  logic [1:0]  n;

  assign c        = char_code;
  assign c_op     = is_op(c);
  assign c_delim  = is_delim(c);
  assign c_word   = is_word_char(c);
  assign c_space  = is_space(c);
  assign c_ends   = c_op || c_delim || c_space;
  assign has_word = (count_r != '0);
  assign in_range = (count_r < CW'(KW_MAX_LEN));
  assign len8     = (count_r > CW'(255)) ? 8'hFF : 8'(count_r);

  // candidate mask after appending c, plus first keyword hit on the current word
  always_comb begin
    kw_found = 1'b0;
    kw_idx   = '0;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      app_cand[k] = cand_r[k] & in_range & kw_char_hit(k, count_r[2:0], c);
      if (cand_r[k] && count_r == CW'(KW_LEN[k])) begin
        kw_found = 1'b1;
        kw_idx   = KW_IDX_W'(k);
      end
    end
  end

  always_comb begin
    word_res      = '0;
    word_res.len  = len8;
    if (digits_r) begin
      word_res.cls = CLS_CONST;
    end else if (kw_found) begin
      word_res.cls = CLS_KEYWORD;
      word_res.kw  = kw_idx;
    end else begin
      word_res.cls = CLS_IDENT;
    end
  end

  // single-character token from normal scanning
  always_comb begin
    tok_res    = '0;
    tok_res.ch = c;
    if (c_op) begin
      tok_res.cls = CLS_OPERATOR;
    end else if (c_delim) begin
      tok_res.cls = CLS_DELIM;
    end else begin
      tok_res.cls = CLS_INVALID;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    pre_res   = '0;
    pre_v     = 1'b0;
    flush_v   = 1'b0;
    tok_v     = 1'b0;
    do_append = 1'b0;
    do_clear  = 1'b0;
    if (end_of_input) begin
      mode_nxt = MODE_NORMAL;
      do_clear = 1'b1;
      unique case (mode_r)
        MODE_SLASH: begin
          pre_v       = 1'b1;
          pre_res.cls = CLS_OPERATOR;
          pre_res.ch  = CH_SLASH;
        end
        MODE_LINE, MODE_BLOCK, MODE_STAR: begin
          pre_v       = 1'b1;
          pre_res.cls = CLS_COMMENT;
        end
        default: flush_v = has_word;
      endcase
    end else begin
      unique case (mode_r)
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (c == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end else begin
            // held slash goes out, then the character scans normally
            mode_nxt    = MODE_NORMAL;
            pre_v       = 1'b1;
            pre_res.cls = CLS_OPERATOR;
            pre_res.ch  = CH_SLASH;
            tok_v       = !c_word && !c_space;
            do_append   = c_word;
          end
        end
        MODE_LINE: begin
          if (c == CH_LF) begin
            mode_nxt    = MODE_NORMAL;
            pre_v       = 1'b1;
            pre_res.cls = CLS_COMMENT;
          end
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) mode_nxt = MODE_STAR;
        end
        MODE_STAR: begin
          if (c == CH_SLASH) begin
            mode_nxt    = MODE_NORMAL;
            pre_v       = 1'b1;
            pre_res.cls = CLS_COMMENT;
          end else if (c != CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end
        end
        default: begin
          mode_nxt  = (c == CH_SLASH) ? MODE_SLASH : MODE_NORMAL;
          flush_v   = c_ends && has_word;
          tok_v     = !c_word && !c_space && (c != CH_SLASH);
          do_append = c_word;
          do_clear  = c_ends;
        end
      endcase
    end
  end

  // pack valid results in order; a held slash and a word flush never coincide
  always_comb begin
    n     = 2'(pre_v) + 2'(flush_v) + 2'(tok_v);
    slot0 = pre_v ? pre_res : (flush_v ? word_res : tok_res);
    slot1 = tok_res;
    slot0.last = (n == 2'd1);
    slot1.last = 1'b1;
    push.n  = accept ? n : 2'd0;
    push.r0 = slot0;
    push.r1 = slot1;
  end

  always_comb begin
    count_nxt  = count_r;
    digits_nxt = digits_r;
    cand_nxt   = cand_r;
    if (do_clear) begin
      count_nxt  = '0;
      digits_nxt = 1'b1;
      cand_nxt   = '1;
    end else if (do_append) begin
      cand_nxt   = app_cand;
      digits_nxt = digits_r & is_digit(c);
      if (count_r < CW'(MAX_WORD_LEN)) count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      count_r  <= '0;
      digits_r <= 1'b1;
      cand_r   <= '1;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      count_r  <= count_nxt;
      digits_r <= digits_nxt;
      cand_r   <= cand_nxt;
    end
  end

endmodule

FILE: rtl/core/tc_result_fifo.sv
// small result queue taking one or two results per cycle, releasing one
module tc_result_fifo import tc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tc_push_t   push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output tc_result_t out_res
);

  tc_result_t            mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;

  assign room      = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    cnt_nxt    = cnt_r + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2) mem_r[wr_ptr_r + FIFO_PTR_W'(1)] <= push.r1;
  end

endmodule

FILE: rtl/core/token_classifier.sv
// token classifier top level: character scanner feeding a result queue
// throughput: one item per cycle while items cause at most one result and out_ready is high; an item
//   with two results sends them one at a time on the single out_ port, buffered by a 4-entry result queue
// reset: synchronous active-low rst_n returns the scanner to normal mode with an empty
//   word and empties the result queue
module token_classifier import tc_pkg::*; #(
  parameter int MAX_WORD_LEN = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_token_class,
  output logic [7:0] out_token_char,
  output logic [3:0] out_keyword_index,
  output logic [7:0] out_word_length,
  output logic       out_last
);

  tc_push_t   push;
  tc_result_t res;
  logic       room;

  assign in_ready = room;

  tc_lexer #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_valid && in_ready),
    .char_code    (in_char_code),
    .end_of_input (in_end_of_input),
    .push         (push)
  );

  tc_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_token_class   = res.cls;
  assign out_token_char    = res.ch;
  assign out_keyword_index = res.kw;
  assign out_word_length   = res.len;
  assign out_last          = res.last;

endmodule

FILE: rtl/core/tc_checker.sv
// port-level checks on the token classifier results, bound to the top level
module tc_checker import tc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_token_class,
  input logic [7:0] out_token_char,
  input logic [3:0] out_keyword_index,
  input logic [7:0] out_word_length,
  input logic       out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_class) &&
      $stable(out_token_char) && $stable(out_word_length) && $stable(out_last))
    else $error("result changed while stalled");

  // word results carry a length and no character
  a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_class == CLS_IDENT || out_token_class == CLS_KEYWORD ||
                  out_token_class == CLS_CONST)
      |-> out_word_length != 8'd0 && out_token_char == 8'd0)
    else $error("word result fields wrong");

  // keyword index only on keywords, and in range
  a_kw_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_class == CLS_KEYWORD) ? (out_keyword_index < 4'd11)
                                                   : (out_keyword_index == 4'd0))
    else $error("keyword index wrong");

  // a comment result carries nothing and always ends its item
  a_comment: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_class == CLS_COMMENT
      |-> out_token_char == 8'd0 && out_word_length == 8'd0 && out_last)
    else $error("comment result fields wrong");

  // single-character tokens carry no length
  a_char_tok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_class == CLS_OPERATOR || out_token_class == CLS_DELIM ||
                  out_token_class == CLS_INVALID)
      |-> out_word_length == 8'd0)
    else $error("character token has a length");

endmodule

bind token_classifier tc_checker u_tc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_token_class   (out_token_class),
  .out_token_char    (out_token_char),
  .out_keyword_index (out_keyword_index),
  .out_word_length   (out_word_length),
  .out_last          (out_last)
);
